// ===== src/dtl_pkg.sv =====
package dtl_pkg;

  // Longest name accepted before the name-too-long error.
  localparam int unsigned MAX_NAME_CHARS = 511;
  localparam int unsigned NAME_W         = $clog2(MAX_NAME_CHARS + 1);

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned KW_COUNT   = 17;
  localparam int unsigned KW_W       = 5;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    KIND_NUMBER    = 3'd0,
    KIND_KEYWORD   = 3'd1,
    KIND_NAME_END  = 3'd2,
    KIND_NAME_CHAR = 3'd3,
    KIND_DELIM     = 3'd4,
    KIND_ERROR     = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_BAD_NUMBER   = 2'd0,
    ERR_NAME_LONG    = 2'd1,
    ERR_UNKNOWN_CHAR = 2'd2
  } err_e;

  // One output word.
  typedef struct packed {
    kind_e               kind;
    logic [VALUE_W-1:0]  value;
    logic [KW_W-1:0]     kw;
    logic [7:0]          ch;
    logic [NAME_W-1:0]   len;
    err_e                err;
    logic                last;
  } result_t;

  // Up to two words written by the lexer core in one cycle.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic                  room;
    logic [FIFO_CNT_W-1:0] level;
  } fifo_status_t;

  // Keyword spellings, right-justified, index order is the keyword code.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'("void"),     64'("bool"),     64'("int8_t"),   64'("int16_t"),
    64'("int32_t"),  64'("int64_t"),  64'("uint8_t"),  64'({"uint16", "_t"}),
    64'({"uint32", "_t"}), 64'({"uint64", "_t"}), 64'("vector"), 64'("vectorR"),
    64'("string"),   64'("stringR"),  64'("false"),    64'("true"),
    64'("static")
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd4, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8,
    4'd8, 4'd6, 4'd7, 4'd6, 4'd7, 4'd5, 4'd4, 4'd6
  };

endpackage

// ===== src/dtl_fifo.sv =====
module dtl_fifo import dtl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  push_t        push_i,
  input  logic         pop_i,
  output result_t      head_o,
  output fifo_status_t status_o
);

  result_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d;
  logic [FIFO_PTR_W-1:0] rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] level_q, level_d;

  always_comb begin
    wr_d    = wr_q + FIFO_PTR_W'(push_i.count);
    rd_d    = rd_q + FIFO_PTR_W'(pop_i);
    level_d = level_q + FIFO_CNT_W'(push_i.count) - FIFO_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      level_q <= level_d;
    end
  end

  // Word storage carries no reset; the level decides what is valid.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + FIFO_PTR_W'(1)] <= push_i.r1;
    end
  end

  assign head_o         = mem_q[rd_q];
  assign status_o.level = level_q;
  assign status_o.room  = (level_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

endmodule

// ===== src/dtl_core.sv =====
module dtl_core import dtl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic [7:0] source_char_i,
  input  logic       room_i,
  output push_t      push_o
);

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_SLASH, MODE_LINE, MODE_BLOCK, MODE_BSTAR,
    MODE_SIGN, MODE_NUMBER, MODE_NAME, MODE_ERROR
  } mode_e;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_L     = 8'h6C;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == 8'h5F);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
           (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == 8'h28) || (c == 8'h29) || (c == 8'h3C) || (c == 8'h3E) ||
           (c == 8'h3D) || (c == 8'h2C) || (c == 8'h3B) || (c == 8'h26);
  endfunction

  function automatic result_t mk(input kind_e kind, input logic [VALUE_W-1:0] val,
                                 input logic [KW_W-1:0] kw, input logic [7:0] ch,
                                 input logic [NAME_W-1:0] len, input err_e err);
    result_t r;
    r.kind  = kind;
    r.value = val;
    r.kw    = kw;
    r.ch    = ch;
    r.len   = len;
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

  // Drops every keyword whose character at this position differs from c.
  function automatic logic [KW_COUNT-1:0] kw_step(input logic [KW_COUNT-1:0] m,
                                                  input logic [NAME_W-1:0] cnt,
                                                  input logic [7:0] c);
    logic [KW_COUNT-1:0] r;
    logic [2:0]          rev;
    logic [7:0]          ex;
    r = m;
    for (int k = 0; k < KW_COUNT; k++) begin
      rev = 3'(KW_LEN[k] - 4'd1) - cnt[2:0];
      ex  = KW_TEXT[k][{rev, 3'b000} +: 8];
      if ((cnt >= NAME_W'(KW_LEN[k])) || (ex != c)) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  // Input register.
  logic       in_vld_q;
  logic       in_cmd_q;
  logic [7:0] in_ch_q;
  logic       fire;

  // Lexer state.
  mode_e               mode_q, mode_d;
  logic [VALUE_W-1:0]  acc_q, acc_d;
  logic                neg_q, neg_d;
  logic [1:0]          suf_q, suf_d;
  logic [NAME_W-1:0]   cnt_q, cnt_d;
  logic [KW_COUNT-1:0] match_q, match_d;

  // Outcome of starting a fresh token on the current character.
  mode_e               st_mode;
  logic [VALUE_W-1:0]  st_acc;
  logic                st_neg;
  logic [NAME_W-1:0]   st_cnt;
  logic [KW_COUNT-1:0] st_match;
  logic                st_emit;
  result_t             st_res;

  logic                take_start;
  logic [1:0]          nres;
  result_t             res [2];
  logic [VALUE_W-1:0]  num_val;
  logic                kw_hit;
  logic [KW_W-1:0]     kw_code;
  result_t             name_res;

  assign fire       = in_vld_q && room_i;
  assign in_ready_o = !in_vld_q || room_i;

  always_comb begin
    st_mode  = MODE_IDLE;
    st_acc   = '0;
    st_neg   = 1'b0;
    st_cnt   = '0;
    st_match = '1;
    st_emit  = 1'b0;
    st_res   = mk(KIND_NUMBER, '0, '0, '0, '0, ERR_BAD_NUMBER);
    if (is_space(in_ch_q)) begin
      st_mode = MODE_IDLE;
    end else if (in_ch_q == CH_SLASH) begin
      st_mode = MODE_SLASH;
    end else if (is_digit(in_ch_q)) begin
      st_mode = MODE_NUMBER;
      st_acc  = VALUE_W'(in_ch_q[3:0]);
    end else if ((in_ch_q == CH_PLUS) || (in_ch_q == CH_MINUS)) begin
      st_mode = MODE_SIGN;
      st_neg  = (in_ch_q == CH_MINUS);
    end else if (is_alpha(in_ch_q)) begin
      st_mode  = MODE_NAME;
      st_cnt   = NAME_W'(1);
      st_match = kw_step('1, '0, in_ch_q);
      st_emit  = 1'b1;
      st_res   = mk(KIND_NAME_CHAR, '0, '0, in_ch_q, '0, ERR_BAD_NUMBER);
    end else if (is_delim(in_ch_q)) begin
      st_mode = MODE_IDLE;
      st_emit = 1'b1;
      st_res  = mk(KIND_DELIM, '0, '0, in_ch_q, '0, ERR_BAD_NUMBER);
    end else begin
      st_mode = MODE_ERROR;
      st_emit = 1'b1;
      st_res  = mk(KIND_ERROR, '0, '0, '0, '0, ERR_UNKNOWN_CHAR);
    end
  end

  // Closing words for a pending number or name.
  always_comb begin
    num_val = neg_q ? (VALUE_W'(0) - acc_q) : acc_q;
    kw_hit  = 1'b0;
    kw_code = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (match_q[k] && (cnt_q == NAME_W'(KW_LEN[k]))) begin
        kw_hit  = 1'b1;
        kw_code = KW_W'(k);
      end
    end
    name_res = kw_hit ? mk(KIND_KEYWORD, '0, kw_code, '0, '0, ERR_BAD_NUMBER)
                      : mk(KIND_NAME_END, '0, '0, '0, cnt_q, ERR_BAD_NUMBER);
  end

  always_comb begin
    mode_d     = mode_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    suf_d      = suf_q;
    cnt_d      = cnt_q;
    match_d    = match_q;
    take_start = 1'b0;
    nres       = 2'd0;
    res[0]     = mk(KIND_NUMBER, '0, '0, '0, '0, ERR_BAD_NUMBER);
    res[1]     = mk(KIND_NUMBER, '0, '0, '0, '0, ERR_BAD_NUMBER);

    if (mode_q == MODE_ERROR) begin
      // Sticky until reset.
    end else if (in_cmd_q) begin
      mode_d  = MODE_IDLE;
      acc_d   = '0;
      neg_d   = 1'b0;
      suf_d   = '0;
      cnt_d   = '0;
      match_d = '1;
      if (mode_q == MODE_NAME) begin
        res[0] = name_res;
        nres   = 2'd1;
      end else if (mode_q == MODE_NUMBER) begin
        res[0] = mk(KIND_NUMBER, num_val, '0, '0, '0, ERR_BAD_NUMBER);
        nres   = 2'd1;
      end else if (mode_q == MODE_SIGN) begin
        res[0] = mk(KIND_ERROR, '0, '0, '0, '0, ERR_BAD_NUMBER);
        nres   = 2'd1;
        mode_d = MODE_ERROR;
      end
    end else begin
      unique case (mode_q)
        MODE_SLASH: begin
          if (in_ch_q == CH_STAR) begin
            mode_d = MODE_BLOCK;
          end else if (in_ch_q == CH_SLASH) begin
            mode_d = MODE_LINE;
          end else begin
            take_start = 1'b1;
          end
        end
        MODE_LINE: begin
          if ((in_ch_q == CH_LF) || (in_ch_q == CH_CR)) begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_BLOCK: begin
          if (in_ch_q == CH_STAR) begin
            mode_d = MODE_BSTAR;
          end
        end
        MODE_BSTAR: begin
          if (in_ch_q == CH_SLASH) begin
            mode_d = MODE_IDLE;
          end else if (in_ch_q != CH_STAR) begin
            mode_d = MODE_BLOCK;
          end
        end
        MODE_SIGN: begin
          if (is_digit(in_ch_q)) begin
            acc_d  = VALUE_W'(in_ch_q[3:0]);
            mode_d = MODE_NUMBER;
          end else begin
            res[0] = mk(KIND_ERROR, '0, '0, '0, '0, ERR_BAD_NUMBER);
            nres   = 2'd1;
            mode_d = MODE_ERROR;
          end
        end
        MODE_NUMBER: begin
          if ((suf_q == 2'd0) && is_digit(in_ch_q)) begin
            acc_d = (acc_q << 3) + (acc_q << 1) + VALUE_W'(in_ch_q[3:0]);
          end else if ((suf_q == 2'd0) && (in_ch_q == CH_U)) begin
            suf_d = 2'd1;
          end else if ((suf_q != 2'd2) && (in_ch_q == CH_L)) begin
            suf_d = 2'd2;
          end else begin
            res[0] = mk(KIND_NUMBER, num_val, '0, '0, '0, ERR_BAD_NUMBER);
            nres   = 2'd1;
            if ((suf_q == 2'd2) && (in_ch_q == CH_L)) begin
              mode_d  = MODE_IDLE;
              acc_d   = '0;
              neg_d   = 1'b0;
              suf_d   = '0;
            end else begin
              take_start = 1'b1;
            end
          end
        end
        MODE_NAME: begin
          if (is_alpha(in_ch_q) || is_digit(in_ch_q)) begin
            if (cnt_q == NAME_W'(MAX_NAME_CHARS)) begin
              res[0] = mk(KIND_ERROR, '0, '0, '0, '0, ERR_NAME_LONG);
              mode_d = MODE_ERROR;
            end else begin
              res[0]  = mk(KIND_NAME_CHAR, '0, '0, in_ch_q, '0, ERR_BAD_NUMBER);
              match_d = kw_step(match_q, cnt_q, in_ch_q);
              cnt_d   = cnt_q + NAME_W'(1);
            end
            nres = 2'd1;
          end else begin
            res[0]     = name_res;
            nres       = 2'd1;
            take_start = 1'b1;
          end
        end
        MODE_ERROR: begin
        end
        default: begin
          take_start = 1'b1;
        end
      endcase

      if (take_start) begin
        mode_d  = st_mode;
        acc_d   = st_acc;
        neg_d   = st_neg;
        suf_d   = '0;
        cnt_d   = st_cnt;
        match_d = st_match;
        if (st_emit) begin
          res[nres[0]] = st_res;
          nres         = nres + 2'd1;
        end
      end
    end

    if (nres == 2'd1) begin
      res[0].last = 1'b1;
    end else if (nres == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= MODE_IDLE;
      acc_q    <= '0;
      neg_q    <= 1'b0;
      suf_q    <= '0;
      cnt_q    <= '0;
      match_q  <= '1;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        mode_q  <= mode_d;
        acc_q   <= acc_d;
        neg_q   <= neg_d;
        suf_q   <= suf_d;
        cnt_q   <= cnt_d;
        match_q <= match_d;
      end
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_cmd_q <= command_i;
      in_ch_q  <= source_char_i;
    end
  end

  assign push_o.count = fire ? nres : 2'd0;
  assign push_o.r0    = res[0];
  assign push_o.r1    = res[1];

endmodule

// ===== src/declaration_token_lexer.sv =====
// Channel  Direction  Handshake               Word
// input    in         in_valid_i/in_ready_o   command_i, source_char_i
// output   out        out_valid_o/out_ready_i kind_o .. last_o (one token word)
//
// An accepted input word lands in an input register; from there the lexer core
// turns it into zero, one or two output words and writes them into a four-entry
// output queue. A new input word is taken every cycle while the queue holds at
// most two words; the output port drains one word per cycle while out_ready_i is
// high, which sets the rate when items produce two words. Reset clears the lexer
// state, the input register valid bit and the queue pointers. A stalled output
// fills the queue and then holds input.
module declaration_token_lexer import dtl_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      command_i,
  input  logic [7:0]                source_char_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                kind_o,
  output logic signed [VALUE_W-1:0] number_value_o,
  output logic [KW_W-1:0]           keyword_code_o,
  output logic [7:0]                char_out_o,
  output logic [NAME_W-1:0]         name_length_o,
  output logic [1:0]                error_code_o,
  output logic                      last_o
);

  push_t        push;
  fifo_status_t status;
  result_t      head;
  logic         pop;
  logic         push_error;

  // The core decodes one character per cycle while the queue has room, closing
  // tokens on the character after them, so one word can cause two results.
  dtl_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .source_char_i (source_char_i),
    .room_i        (status.room),
    .push_o        (push)
  );

  // The queue parts the lexer from the consumer so a waiting word does not
  // block the next character while the queue has room.
  dtl_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  assign out_valid_o    = (status.level != '0);
  assign pop            = out_valid_o && out_ready_i;
  assign kind_o         = head.kind;
  assign number_value_o = head.value;
  assign keyword_code_o = head.kw;
  assign char_out_o     = head.ch;
  assign name_length_o  = head.len;
  assign error_code_o   = head.err;
  assign last_o         = head.last;

  // An error word is always the last word that its item writes.
  assign push_error = ((push.count == 2'd1) && (push.r0.kind == KIND_ERROR)) ||
                      ((push.count == 2'd2) && (push.r1.kind == KIND_ERROR));

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count != 2'd0) |-> $past(status.room) || status.room)
    else $error("words written without queue room");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.level <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count == 2'd2) |-> (!push.r0.last && push.r1.last))
    else $error("last flag misplaced on a two-word item");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_error |=> (push.count == 2'd0))
    else $error("word produced after an error");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import dtl_pkg::*;

  // A stall of the receiver is the longest stretch in which no word moves.
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  // Input words offered in each of the three random phases.
  localparam int PHASE_WORDS = 165;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum int {
    LX_IDLE, LX_SLASH, LX_LINE, LX_BLOCK, LX_BSTAR, LX_SIGN, LX_NUMBER, LX_NAME, LX_ERROR
  } lex_mode_e;

  localparam int SFX_DIGITS = 0;
  localparam int SFX_U = 1;
  localparam int SFX_L = 2;

  // Tracks the lexer state and keeps the token words that are still due.
  class token_scoreboard;
    lex_mode_e mode;
    logic [63:0] acc;
    bit neg;
    int sfx;
    int name_len;
    string head;
    string kw_names[KW_COUNT];
    result_t pending[$];
    result_t batch[$];
    int errors;
    int checked;

    function new();
      kw_names = '{"void", "bool", "int8_t", "int16_t", "int32_t", "int64_t",
                   "uint8_t", string'({"uint16", "_t"}), string'({"uint32", "_t"}),
                   string'({"uint64", "_t"}), "vector", "vectorR",
                   "string", "stringR", "false", "true", "static"};
      mode = LX_IDLE;
      clear_tok();
      errors = 0;
      checked = 0;
    endfunction

    function void clear_tok();
      acc = '0;
      neg = 1'b0;
      sfx = SFX_DIGITS;
      name_len = 0;
      head = "";
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit is_space(logic [7:0] c);
      return c == " " || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_VT || c == CH_FF;
    endfunction

    function bit is_delim(logic [7:0] c);
      return c == "(" || c == ")" || c == "<" || c == ">" || c == "=" ||
             c == "," || c == ";" || c == "&";
    endfunction

    // True for every byte that may open a token or be skipped in idle.
    function bit is_known(logic [7:0] c);
      return is_space(c) || c == "/" || is_digit(c) || c == "+" || c == "-" ||
             is_alpha(c) || is_delim(c);
    endfunction

    function void push(kind_e k, logic [63:0] v, logic [KW_W-1:0] code,
                       logic [7:0] c, logic [NAME_W-1:0] n, err_e e);
      result_t r;
      r.kind = k;
      r.value = v;
      r.kw = code;
      r.ch = c;
      r.len = n;
      r.err = e;
      r.last = 1'b0;
      batch.push_back(r);
    endfunction

    function void raise_err(err_e code);
      push(KIND_ERROR, '0, '0, '0, '0, code);
      clear_tok();
      mode = LX_ERROR;
    endfunction

    function void add_char(logic [7:0] c);
      if (name_len + 1 > MAX_NAME_CHARS) begin
        raise_err(ERR_NAME_LONG);
        return;
      end
      // Only the first eight characters matter for keyword matching.
      if (name_len < 8) head = $sformatf("%s%c", head, c);
      name_len++;
      push(KIND_NAME_CHAR, '0, '0, c, '0, ERR_BAD_NUMBER);
    endfunction

    function void close_name();
      for (int k = 0; k < KW_COUNT; k++) begin
        if (name_len <= 8 && head == kw_names[k]) begin
          push(KIND_KEYWORD, '0, k, '0, '0, ERR_BAD_NUMBER);
          clear_tok();
          mode = LX_IDLE;
          return;
        end
      end
      push(KIND_NAME_END, '0, '0, '0, name_len, ERR_BAD_NUMBER);
      clear_tok();
      mode = LX_IDLE;
    endfunction

    function void close_number();
      push(KIND_NUMBER, neg ? 64'd0 - acc : acc, '0, '0, '0, ERR_BAD_NUMBER);
      clear_tok();
      mode = LX_IDLE;
    endfunction

    function void begin_tok(logic [7:0] c);
      clear_tok();
      if (is_space(c)) begin
        mode = LX_IDLE;
      end else if (c == "/") begin
        mode = LX_SLASH;
      end else if (is_digit(c)) begin
        acc = 64'(c - "0");
        mode = LX_NUMBER;
      end else if (c == "+" || c == "-") begin
        neg = (c == "-");
        mode = LX_SIGN;
      end else if (is_alpha(c)) begin
        mode = LX_NAME;
        add_char(c);
      end else if (is_delim(c)) begin
        mode = LX_IDLE;
        push(KIND_DELIM, '0, '0, c, '0, ERR_BAD_NUMBER);
      end else begin
        raise_err(ERR_UNKNOWN_CHAR);
      end
    endfunction

    function void lex_step(bit eoi, logic [7:0] c);
      if (mode == LX_ERROR) return;
      if (eoi) begin
        if (mode == LX_NAME) close_name();
        else if (mode == LX_NUMBER) close_number();
        else if (mode == LX_SIGN) raise_err(ERR_BAD_NUMBER);
        if (mode != LX_ERROR) begin
          mode = LX_IDLE;
          clear_tok();
        end
        return;
      end
      case (mode)
        LX_SLASH: begin
          if (c == "*") mode = LX_BLOCK;
          else if (c == "/") mode = LX_LINE;
          else begin_tok(c);
        end
        LX_LINE: begin
          if (c == CH_LF || c == CH_CR) mode = LX_IDLE;
        end
        LX_BLOCK: begin
          if (c == "*") mode = LX_BSTAR;
        end
        LX_BSTAR: begin
          if (c == "/") mode = LX_IDLE;
          else if (c != "*") mode = LX_BLOCK;
        end
        LX_SIGN: begin
          if (is_digit(c)) begin
            acc = 64'(c - "0");
            mode = LX_NUMBER;
          end else begin
            raise_err(ERR_BAD_NUMBER);
          end
        end
        LX_NUMBER: begin
          if (sfx == SFX_DIGITS && is_digit(c)) begin
            acc = acc * 64'd10 + 64'(c - "0");
          end else if (sfx == SFX_DIGITS && c == "u") begin
            sfx = SFX_U;
          end else if (sfx != SFX_L && c == "l") begin
            sfx = SFX_L;
          end else if (sfx == SFX_L && c == "l") begin
            close_number();
          end else begin
            close_number();
            begin_tok(c);
          end
        end
        LX_NAME: begin
          if (is_alpha(c) || is_digit(c)) begin
            add_char(c);
          end else begin
            close_name();
            begin_tok(c);
          end
        end
        default: begin_tok(c);
      endcase
    endfunction

    // Called for each accepted input word; returns how many token words it causes.
    function int note_input(bit eoi, logic [7:0] c);
      batch.delete();
      lex_step(eoi, c);
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending.push_back(batch[i]);
      return batch.size();
    endfunction

    function void cmp_field(string fname, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: token word of kind %0d arrived with nothing expected", $time,
                   got.kind);
        return;
      end
      want = pending.pop_front();
      checked++;
      cmp_field("kind", want.kind, got.kind);
      cmp_field("number_value", want.value, got.value);
      cmp_field("keyword_code", want.kw, got.kw);
      cmp_field("char_out", want.ch, got.ch);
      cmp_field("name_length", want.len, got.len);
      cmp_field("error_code", want.err, got.err);
      cmp_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [7:0] src = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] kind;
  logic signed [VALUE_W-1:0] value;
  logic [KW_W-1:0] kw;
  logic [7:0] ch;
  logic [NAME_W-1:0] len;
  logic [1:0] err;
  logic last;

  token_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int n_sent = 0;
  int n_live = 0;
  string tail_desc = "";

  declaration_token_lexer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (cmd),
    .source_char_i  (src),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .number_value_o (value),
    .keyword_code_o (kw),
    .char_out_o     (ch),
    .name_length_o  (len),
    .error_code_o   (err),
    .last_o         (last)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic result_t dut_word();
    result_t w;
    w.kind = kind_e'(kind);
    w.value = value;
    w.kw = kw;
    w.ch = ch;
    w.len = len;
    w.err = err_e'(err);
    w.last = last;
    return w;
  endfunction

  // Offers one input word, with random idle cycles in front, and waits until it is taken.
  task automatic send_word(bit eoi, logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd <= eoi;
    src <= c;
    do @(posedge clk_i); while (!in_ready);
    n_sent++;
    if (sb.note_input(eoi, c) > 0) n_live++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  task automatic send_eoi();
    send_word(1'b1, 8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] name_byte(bit first);
    int r;
    r = $urandom_range(first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] space_byte();
    logic [7:0] pick[6];
    pick = '{" ", CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF};
    return pick[$urandom_range(5)];
  endfunction

  function automatic logic [7:0] delim_byte();
    string delims;
    delims = "()<>=,;&";
    return delims[$urandom_range(7)];
  endfunction

  task automatic random_name();
    string word;
    int n;
    word = sb.kw_names[$urandom_range(KW_COUNT - 1)];
    case ($urandom_range(3))
      0: begin
        n = $urandom_range(1, 12);
        send_word(1'b0, name_byte(1'b1));
        for (int i = 1; i < n; i++) send_word(1'b0, name_byte(1'b0));
      end
      1: send_text(word);
      2: begin
        // A keyword with a tail comes out as a plain name, unless the tail makes another keyword.
        send_text(word);
        repeat ($urandom_range(1, 3)) send_word(1'b0, name_byte(1'b0));
      end
      default: send_text(word.substr(0, $urandom_range(word.len() - 2)));
    endcase
  endtask

  task automatic random_number();
    string big[5];
    string sfx[9];
    int n;
    big = '{"9223372036854775807", "9223372036854775808", "18446744073709551615",
            "18446744073709551616", "99999999999999999999999"};
    sfx = '{"", "u", "l", "ul", "ll", "ull", "lu", "uu", "lll"};
    case ($urandom_range(2))
      0: ;
      1: send_word(1'b0, "+");
      default: send_word(1'b0, "-");
    endcase
    if ($urandom_range(9) == 0) begin
      send_text(big[$urandom_range(4)]);
    end else begin
      n = ($urandom_range(6) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 3);
      repeat (n) send_word(1'b0, 8'("0" + $urandom_range(9)));
    end
    send_text(sfx[$urandom_range(8)]);
  endtask

  task automatic line_comment();
    logic [7:0] b;
    send_text("//");
    repeat ($urandom_range(12)) begin
      do b = 8'($urandom_range(255)); while (b == CH_LF || b == CH_CR);
      send_word(1'b0, b);
    end
    if ($urandom_range(4) == 0) send_eoi();
    else send_word(1'b0, $urandom_range(1) ? CH_LF : CH_CR);
  endtask

  task automatic block_comment();
    logic [7:0] b;
    logic [7:0] prev;
    prev = 8'd0;
    send_text("/*");
    repeat ($urandom_range(10)) begin
      b = 8'($urandom_range(255));
      // A slash right after a star would close the comment early.
      if (prev == "*" && b == "/") b = "#";
      send_word(1'b0, b);
      prev = b;
    end
    if ($urandom_range(6) == 0) begin
      send_eoi();
    end else begin
      repeat ($urandom_range(1, 3)) send_word(1'b0, "*");
      send_word(1'b0, "/");
    end
  endtask

  task automatic lone_slash();
    send_word(1'b0, "/");
    case ($urandom_range(4))
      0: send_eoi();
      1, 2: send_word(1'b0, space_byte());
      default: send_word(1'b0, delim_byte());
    endcase
  endtask

  task automatic random_token();
    int r;
    r = $urandom_range(99);
    if (r < 15) send_word(1'b0, space_byte());
    else if (r < 35) random_name();
    else if (r < 57) random_number();
    else if (r < 72) send_word(1'b0, delim_byte());
    else if (r < 79) line_comment();
    else if (r < 86) block_comment();
    else if (r < 92) lone_slash();
    else send_eoi();
  endtask

  // Each run ends on one of the sticky errors, chosen by the seed, plus some noise.
  task automatic error_tail();
    logic [7:0] b;
    case ($urandom_range(2))
      0: begin
        tail_desc = "sign before a non-digit";
        send_word(1'b0, "+");
        send_word(1'b0, name_byte(1'b1));
      end
      1: begin
        tail_desc = "sign before end of input";
        send_word(1'b0, "-");
        send_eoi();
      end
      default: begin
        tail_desc = "unknown character";
        do b = 8'($urandom_range(255)); while (sb.is_known(b));
        send_word(1'b0, b);
      end
    endcase
    // Nothing may come out after the error.
    repeat (12) send_word($urandom_range(3) == 0, 8'($urandom_range(255)));
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin : drain_proc
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) sb.check_result(dut_word());
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: no word moved for %0d cycles", quiet);
    $display("tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int mark;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: keyword, names, double-l and u-l suffixes, delimiters, a lone slash,
    // a star run before the comment end, and end of input in a comment and on a number.
    send_text("true x9=-5ll+0ul;");
    send_text("/y/*a**/");
    send_eoi();
    send_text("//");
    send_eoi();
    send_text("7");
    send_eoi();

    send_idle_pct = 22;
    recv_idle_pct = 61;
    mark = n_sent + PHASE_WORDS;
    while (n_sent < mark) random_token();

    send_idle_pct = 61;
    recv_idle_pct = 22;
    mark = n_sent + PHASE_WORDS;
    while (n_sent < mark) random_token();

    // No idling; the receiver holds off for a long stretch while the sender keeps
    // offering words, so the output queue fills and the input stalls.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    mark = n_sent + PHASE_WORDS;
    while (n_sent < mark) random_token();

    error_tail();
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d input words (%0d causing tokens), %0d token words checked",
             n_sent, n_live, sb.checked);
    $display("tb: closing error case: %s; %0d mismatches", tail_desc, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dtl_pkg.sv
src/dtl_fifo.sv
src/dtl_core.sv
src/declaration_token_lexer.sv
sim/tb.sv
